// ===== rtl/bqd_pkg.sv =====
package bqd_pkg;

  localparam int unsigned COEF_W     = 32;  // coefficient register width
  localparam int unsigned COEF_EXT_W = 34;  // coefficient sums (num, den)
  localparam int unsigned ACC_W      = 56;  // delay accumulator width
  localparam int unsigned DVS_W      = 33;  // magnitude of the DC denominator
  localparam int unsigned NUM_COEFS  = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned KIND_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FILTER = 2'd0,
    KIND_PRESET = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FF0 = 3'd0,
    CFG_FF1 = 3'd1,
    CFG_FF2 = 3'd2,
    CFG_FB1 = 3'd3,
    CFG_FB2 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/bqd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bqd_div #(
  parameter int unsigned DVD_W = 57,
  parameter int unsigned DVS_W = 33
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DVD_W-1:0]    dividend_i,
  input  logic [DVS_W-1:0]    divisor_i,
  output bqd_pkg::div_stat_t  stat_o,
  output logic [DVD_W-1:0]    quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(DVD_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // borrow clear means the shifted remainder holds the divisor
      if (!diff[DVS_W+1]) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== rtl/biquad_iir_filter_core.sv =====
// Biquad IIR filter, transposed direct form II, one shared multiplier.
// Filter item: states M0, Y, FB1, Z1, FB2, Z2, then DONE; clear, unused
// kinds and a preset with zero DC denominator go straight from IDLE to DONE.
// Preset item: MUL, DIV, then WAIT on the bit-serial DC-gain divider
// (SAMPLE_WIDTH + 33 quotient bits, one per cycle), then FB2, Z2, FB1, Z1 and DONE.
// One item at a time; the next item is taken while a result waits on the output.
// Reset: coefficients to passthrough (ff0 = 1.0), both accumulators to zero.
module biquad_iir_filter_core #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned COEF_FRAC_BITS = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bqd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bqd_pkg::COEF_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bqd_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      value_o,
  output logic                                divide_fault_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned ACC_W = bqd_pkg::ACC_W;
  localparam int unsigned CXW   = bqd_pkg::COEF_EXT_W;
  localparam int unsigned DVS_W = bqd_pkg::DVS_W;
  localparam int unsigned PW    = SW + CXW;         // product width
  localparam int unsigned EW    = PW + ACC_W;       // headroom for saturation
  localparam int unsigned RW    = ACC_W + 2 + SW;   // output rounding width
  localparam int unsigned DVD_W = SW + 33;          // |x*num| + den/2 fits here

  localparam logic signed [CXW-1:0] DEN_ONE  = CXW'(1) << COEF_FRAC_BITS;
  localparam logic signed [RW-1:0]  HALF     = RW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [bqd_pkg::COEF_W-1:0] FF0_RESET =
    bqd_pkg::COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SW-1:0]    SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]    SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_F_M0   = 15'b000000000000010,
    S_F_Y    = 15'b000000000000100,
    S_F_FB1  = 15'b000000000001000,
    S_F_Z1   = 15'b000000000010000,
    S_F_FB2  = 15'b000000000100000,
    S_F_Z2   = 15'b000000001000000,
    S_P_MUL  = 15'b000000010000000,
    S_P_DIV  = 15'b000000100000000,
    S_P_WAIT = 15'b000001000000000,
    S_P_FB2  = 15'b000010000000000,
    S_P_Z2   = 15'b000100000000000,
    S_P_FB1  = 15'b001000000000000,
    S_P_Z1   = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_e;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [EW-1:0] v);
    logic [EW-ACC_W:0] top;
    top = v[EW-1:ACC_W-1];
    priority if (&top || ~|top) begin
      return v[ACC_W-1:0];
    end else if (v[EW-1]) begin
      return ACC_MIN;
    end else begin
      return ACC_MAX;
    end
  endfunction

  function automatic logic signed [SW-1:0] sat_smp(input logic signed [RW-1:0] v);
    logic [RW-SW:0] top;
    top = v[RW-1:SW-1];
    priority if (&top || ~|top) begin
      return v[SW-1:0];
    end else if (v[RW-1]) begin
      return SMP_MIN;
    end else begin
      return SMP_MAX;
    end
  endfunction

  state_e state_q, state_d;

  logic [bqd_pkg::COEF_W-1:0] coef_q [bqd_pkg::NUM_COEFS];

  logic signed [SW-1:0]    x_q, x_d;
  logic signed [SW-1:0]    y_q, y_d;
  logic signed [PW-1:0]    p_q;
  logic signed [ACC_W-1:0] t_q, t_d;
  logic signed [ACC_W-1:0] d1_q, d1_d;
  logic signed [ACC_W-1:0] d2_q, d2_d;
  logic                    fault_q, fault_d;
  logic [DVS_W-1:0]        md_q, md_d;
  logic                    den_neg_q, den_neg_d;
  logic                    neg_q, neg_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [SW-1:0]    value_q, value_d;
  logic                    ofault_q, ofault_d;

  // shared multiplier
  logic signed [SW-1:0]  mul_a;
  logic signed [CXW-1:0] mul_b;
  logic signed [PW-1:0]  prod;

  logic signed [CXW-1:0] c_ff0, c_ff1, c_ff2, c_fb1, c_fb2;
  logic signed [CXW-1:0] num, den;
  logic [DVS_W-1:0]      den_mag;

  logic signed [ACC_W-1:0] sp;
  logic signed [EW-1:0]    z1sum, z2sum;
  logic signed [RW-1:0]    rsum, rsh;
  logic signed [SW-1:0]    y_round;

  logic [PW-1:0]         p_mag;
  logic [DVD_W-1:0]      dividend;
  logic                  div_start;
  bqd_pkg::div_stat_t    div_stat;
  logic [DVD_W-1:0]      quo;
  logic                  quo_big;
  logic [SW-1:0]         quo_lo;
  logic signed [SW-1:0]  y_quot;

  assign c_ff0 = CXW'($signed(coef_q[bqd_pkg::CFG_FF0]));
  assign c_ff1 = CXW'($signed(coef_q[bqd_pkg::CFG_FF1]));
  assign c_ff2 = CXW'($signed(coef_q[bqd_pkg::CFG_FF2]));
  assign c_fb1 = CXW'($signed(coef_q[bqd_pkg::CFG_FB1]));
  assign c_fb2 = CXW'($signed(coef_q[bqd_pkg::CFG_FB2]));

  assign num     = c_ff0 + c_ff1 + c_ff2;
  assign den     = DEN_ONE + c_fb1 + c_fb2;
  assign den_mag = den[CXW-1] ? DVS_W'(-den) : DVS_W'(den);

  // operand select: every state loads the product register
  always_comb begin
    mul_a = x_q;
    mul_b = c_ff0;
    unique case (state_q)
      S_F_Y:    mul_b = c_ff1;
      S_F_FB1:  begin mul_a = y_q; mul_b = c_fb1; end
      S_F_Z1:   mul_b = c_ff2;
      S_F_FB2:  begin mul_a = y_q; mul_b = c_fb2; end
      S_P_MUL:  mul_b = num;
      S_P_WAIT: mul_b = c_ff2;
      S_P_FB2:  begin mul_a = y_quot; mul_b = c_fb2; end
      S_P_Z2:   mul_b = c_ff1;
      S_P_FB1:  begin mul_a = y_q; mul_b = c_fb1; end
      default:  mul_b = c_ff0;
    endcase
  end

  assign prod = mul_a * mul_b;

  assign sp    = sat_acc(EW'(p_q));
  assign z1sum = EW'(t_q) + EW'(d2_q) - EW'(sp);
  assign z2sum = EW'(t_q) - EW'(sp);

  assign rsum    = RW'(sp) + RW'(d1_q) + HALF;
  assign rsh     = rsum >>> COEF_FRAC_BITS;
  assign y_round = sat_smp(rsh);

  assign p_mag    = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);
  assign dividend = DVD_W'(p_mag) + DVD_W'(md_q >> 1);

  bqd_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (md_q),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  assign quo_big = |quo[DVD_W-1:SW-1];
  assign quo_lo  = quo[SW-1:0];

  always_comb begin
    if (neg_q) begin
      y_quot = quo_big ? SMP_MIN : -$signed(quo_lo);
    end else begin
      y_quot = quo_big ? SMP_MAX : $signed(quo_lo);
    end
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    t_d         = t_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    fault_d     = fault_q;
    md_d        = md_q;
    den_neg_d   = den_neg_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    ofault_d    = ofault_q;
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = sample_i;
          y_d     = '0;
          fault_d = 1'b0;
          unique case (kind_i)
            bqd_pkg::KIND_FILTER: state_d = S_F_M0;
            bqd_pkg::KIND_PRESET: begin
              md_d      = den_mag;
              den_neg_d = den[CXW-1];
              if (den == '0) begin
                fault_d = 1'b1;
                d1_d    = '0;
                d2_d    = '0;
                state_d = S_DONE;
              end else begin
                state_d = S_P_MUL;
              end
            end
            bqd_pkg::KIND_CLEAR: begin
              d1_d    = '0;
              d2_d    = '0;
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_F_M0:  state_d = S_F_Y;
      S_F_Y: begin
        y_d     = y_round;
        state_d = S_F_FB1;
      end
      S_F_FB1: begin
        t_d     = sp;
        state_d = S_F_Z1;
      end
      S_F_Z1: begin
        d1_d    = sat_acc(z1sum);  // old delay_two
        state_d = S_F_FB2;
      end
      S_F_FB2: begin
        t_d     = sp;
        state_d = S_F_Z2;
      end
      S_F_Z2: begin
        d2_d    = sat_acc(z2sum);
        state_d = S_DONE;
      end
      S_P_MUL: state_d = S_P_DIV;
      S_P_DIV: begin
        div_start = 1'b1;
        neg_d     = p_q[PW-1] ^ den_neg_q;
        state_d   = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (div_stat.done) begin
          y_d     = y_quot;
          state_d = S_P_FB2;
        end
      end
      S_P_FB2: begin
        t_d     = sp;
        state_d = S_P_Z2;
      end
      S_P_Z2: begin
        d2_d    = sat_acc(z2sum);
        state_d = S_P_FB1;
      end
      S_P_FB1: begin
        t_d     = sp;
        state_d = S_P_Z1;
      end
      S_P_Z1: begin
        d1_d    = sat_acc(z1sum);  // uses the new delay_two
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = y_q;
          ofault_d    = fault_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      d1_q        <= '0;
      d2_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < bqd_pkg::NUM_COEFS; i++) begin
        coef_q[i] <= (i == 0) ? FF0_RESET : '0;
      end
    end else begin
      state_q     <= state_d;
      d1_q        <= d1_d;
      d2_q        <= d2_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i < bqd_pkg::CFG_IDX_W'(bqd_pkg::NUM_COEFS))) begin
        coef_q[cfg_index_i] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    p_q       <= prod;
    t_q       <= t_d;
    fault_q   <= fault_d;
    md_q      <= md_d;
    den_neg_q <= den_neg_d;
    neg_q     <= neg_d;
    value_q   <= value_d;
    ofault_q  <= ofault_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign divide_fault_o = ofault_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_div_idle_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy)
    else $error("divider busy while taking a new item");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_P_WAIT))
    else $error("divider finished outside of the preset wait");

  a_fault_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_fault_o) |-> (value_o == '0))
    else $error("divide fault with nonzero value");

endmodule
